>>> src/stl_pkg.sv
// Package for the source token lexer: token codes, scan modes, keyword table.
// No dependencies; used by every file of the block but the stream interface.
package stl_pkg;

	localparam int unsigned MAX_SOURCE_BYTES = 1048576;
	localparam int unsigned LINE_MAX_COUNT = 1048576;
	localparam int unsigned TYPE_W = 6;
	localparam int unsigned OFFS_W = 20;
	localparam int unsigned LEN_W = 21;
	localparam int unsigned LINE_W = 21;

	localparam logic [TYPE_W-1:0] T_LPAREN = 6'd0;
	localparam logic [TYPE_W-1:0] T_RPAREN = 6'd1;
	localparam logic [TYPE_W-1:0] T_LBRACE = 6'd2;
	localparam logic [TYPE_W-1:0] T_RBRACE = 6'd3;
	localparam logic [TYPE_W-1:0] T_COMMA = 6'd4;
	localparam logic [TYPE_W-1:0] T_SEMI = 6'd5;
	localparam logic [TYPE_W-1:0] T_PLUS = 6'd6;
	localparam logic [TYPE_W-1:0] T_MINUS = 6'd8;
	localparam logic [TYPE_W-1:0] T_SLASH = 6'd10;
	localparam logic [TYPE_W-1:0] T_STAR = 6'd12;
	localparam logic [TYPE_W-1:0] T_CARET = 6'd14;
	localparam logic [TYPE_W-1:0] T_BANG = 6'd16;
	localparam logic [TYPE_W-1:0] T_EQUAL = 6'd18;
	localparam logic [TYPE_W-1:0] T_GREATER = 6'd20;
	localparam logic [TYPE_W-1:0] T_LESS = 6'd22;
	localparam logic [TYPE_W-1:0] T_DOT = 6'd24;
	localparam logic [TYPE_W-1:0] T_NUMBER = 6'd25;
	localparam logic [TYPE_W-1:0] T_STRING = 6'd26;
	localparam logic [TYPE_W-1:0] T_IDENT = 6'd27;
	localparam logic [TYPE_W-1:0] T_KW0 = 6'd28;
	localparam logic [TYPE_W-1:0] T_ERROR = 6'd44;
	localparam logic [TYPE_W-1:0] T_EOF = 6'd45;

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_DQ = 8'h22;
	localparam logic [7:0] CH_SQ = 8'h27;

	typedef enum logic [7:0] {
		M_IDLE    = 8'b0000_0001,
		M_COMMENT = 8'b0000_0010,
		M_OP      = 8'b0000_0100,
		M_DOT     = 8'b0000_1000,
		M_INT     = 8'b0001_0000,
		M_FRAC    = 8'b0010_0000,
		M_STRING  = 8'b0100_0000,
		M_IDENT   = 8'b1000_0000
	} mode_t;

	// Input beat: end-of-input flag and source byte
	typedef struct packed {
		logic       kind;
		logic [7:0] char_byte;
	} lex_in_t;

	typedef struct packed {
		logic [TYPE_W-1:0] token_type;
		logic [OFFS_W-1:0] start_offset;
		logic [LEN_W-1:0]  token_length;
		logic [LINE_W-1:0] line_number;
		logic              last;
	} tok_t;

	// Keywords packed little-endian, with their lengths.
	localparam logic [63:0] KW_TEXT [16] = '{
		64'h0000_0000_6575_7274, 64'h0000_0065_736c_6166,
		64'h0000_0000_656e_6f6e, 64'h0000_0074_6e69_7270,
		64'h0000_0000_0000_6669, 64'h0000_0000_6573_6c65,
		64'h0000_0000_706f_6f6c, 64'h0000_0065_6c69_6877,
		64'h0000_0000_0072_6f66, 64'h0000_0000_0000_6e69,
		64'h6575_6e69_746e_6f63, 64'h0000_006b_6165_7262,
		64'h0000_6e72_7574_6572, 64'h0000_0000_636e_7566,
		64'h0000_0000_0072_6176, 64'h0000_0000_7469_7865
	};
	localparam logic [3:0] KW_LEN [16] = '{
		4'd4, 4'd5, 4'd4, 4'd5, 4'd2, 4'd4, 4'd4, 4'd5,
		4'd3, 4'd2, 4'd8, 4'd5, 4'd6, 4'd4, 4'd3, 4'd4
	};

	function automatic logic [TYPE_W-1:0] op_base(input logic [7:0] c);
		case (c)
			8'h2B: return T_PLUS;
			8'h2D: return T_MINUS;
			8'h2F: return T_SLASH;
			8'h2A: return T_STAR;
			8'h5E: return T_CARET;
			8'h21: return T_BANG;
			8'h3D: return T_EQUAL;
			8'h3E: return T_GREATER;
			8'h3C: return T_LESS;
			default: return '0;
		endcase
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

endpackage

>>> src/stl_stream_if.sv
// Valid/ready stream interface with a generic payload type.
// Depends on stl_pkg only through the payload types its users pass in.
interface stl_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/stl_kw_match.sv
// Keyword lookup for an identifier prefix: compare against the 16 keywords.
// Depends on stl_pkg for the keyword table and token codes.
module stl_kw_match (
	input  logic [63:0]                    prefix,
	input  logic [3:0]                     length,
	output logic [stl_pkg::TYPE_W-1:0]     token_type
);
	// Compare all keywords in parallel, pick the hit
	always_comb begin
		token_type = stl_pkg::T_IDENT;
		for (int k = 0; k < 16; k++) begin
			if (length == stl_pkg::KW_LEN[k] && prefix == stl_pkg::KW_TEXT[k]) begin
				token_type = stl_pkg::T_KW0 + stl_pkg::TYPE_W'(k);
			end
		end
	end
endmodule

>>> src/source_token_lexer_unit.sv
// Source token lexer: one byte per beat scanner with a two-entry result queue.
// Tokens enter the registered queue when the byte completing them is accepted.
// Throughput: one input byte per cycle while the queue is empty, or holds one
// entry being popped; else input stalls. A two-token byte pushes both at once.
// Reset: scanner idle, position 0, line 1, result queue empty.
module source_token_lexer_unit #(
	parameter longint unsigned MaxSourceBytes = 64'(stl_pkg::MAX_SOURCE_BYTES)
) (
	input logic clk,
	input logic arst_n,
	stl_stream_if.sink   in_ch,
	stl_stream_if.source out_ch
);
	localparam int unsigned POS_W = $clog2(MaxSourceBytes + 1);

	stl_pkg::mode_t   mode_q;
	logic [7:0]       pend_q;
	logic             quote_q;
	logic [POS_W-1:0] start_q, pos_q;
	logic [stl_pkg::LINE_W-1:0] line_q;
	logic [63:0]      pfx_q;
	logic [3:0]       ilen_q;

	// Output queue: two entries
	stl_pkg::tok_t    qd_q [2];
	logic [1:0]       cnt_q;
	logic             head_q;

	logic             kind;
	logic [7:0]       c;
	logic             fire, endi;
	logic [stl_pkg::TYPE_W-1:0] kw_type;

	assign kind = in_ch.data.kind;
	assign c    = in_ch.data.char_byte;
	assign endi = kind || c == 8'h00;
	assign in_ch.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ch.ready);
	assign fire = in_ch.valid && in_ch.ready;

	stl_kw_match u_kw (.prefix(pfx_q), .length(ilen_q), .token_type(kw_type));

	// Next-state and token generation
	stl_pkg::mode_t   mode_d;
	logic [7:0]       pend_d;
	logic             quote_d;
	logic [POS_W-1:0] start_d, pos_d;
	logic [stl_pkg::LINE_W-1:0] line_d;
	logic [63:0]      pfx_d;
	logic [3:0]       ilen_d;
	logic [1:0]       nt;
	logic [stl_pkg::TYPE_W-1:0] t0, t1;
	logic [POS_W-1:0] s0, s1, e0, e1;
	logic             fresh;
	logic [POS_W-1:0] pos_inc;

	function automatic logic [POS_W-1:0] adv(input logic [POS_W-1:0] p);
		return (p < POS_W'(MaxSourceBytes)) ? p + 1'b1 : p;
	endfunction

	always_comb begin
		mode_d = mode_q; pend_d = pend_q; quote_d = quote_q; start_d = start_q;
		pos_d = pos_q; line_d = line_q; pfx_d = pfx_q; ilen_d = ilen_q;
		nt = 2'd0; t0 = '0; t1 = '0; s0 = start_q; s1 = pos_q; e0 = pos_q; e1 = pos_q;
		fresh = 1'b0;
		pos_inc = adv(pos_q);
		if (endi) begin
			nt = 2'd1; t0 = stl_pkg::T_EOF; s0 = pos_q; e0 = pos_q;
			unique case (mode_q)
				stl_pkg::M_OP: begin nt = 2'd2; t0 = stl_pkg::op_base(pend_q); end
				stl_pkg::M_DOT: begin nt = 2'd2; t0 = stl_pkg::T_DOT; end
				stl_pkg::M_INT, stl_pkg::M_FRAC: begin nt = 2'd2; t0 = stl_pkg::T_NUMBER; end
				stl_pkg::M_STRING: begin nt = 2'd2; t0 = stl_pkg::T_ERROR; end
				stl_pkg::M_IDENT: begin nt = 2'd2; t0 = kw_type; end
				default: ;
			endcase
			if (nt == 2'd2) begin
				s0 = start_q; t1 = stl_pkg::T_EOF; s1 = pos_q; e1 = pos_q;
			end
			mode_d = stl_pkg::M_IDLE; pend_d = '0; quote_d = 1'b0; start_d = '0;
			pos_d = '0; line_d = stl_pkg::LINE_W'(1); pfx_d = '0; ilen_d = '0;
		end else begin
			unique case (mode_q)
				stl_pkg::M_COMMENT: begin
					if (c == stl_pkg::CH_NL) fresh = 1'b1;
					else pos_d = pos_inc;
				end
				stl_pkg::M_OP: begin
					if (c == stl_pkg::CH_EQ) begin
						pos_d = pos_inc; nt = 2'd1;
						t0 = stl_pkg::op_base(pend_q) + 1'b1; e0 = pos_inc;
						mode_d = stl_pkg::M_IDLE;
					end else begin
						nt = 2'd1; t0 = stl_pkg::op_base(pend_q); fresh = 1'b1;
					end
				end
				stl_pkg::M_DOT: begin
					if (stl_pkg::is_digit(c)) begin
						mode_d = stl_pkg::M_INT; pos_d = pos_inc;
					end else begin
						nt = 2'd1; t0 = stl_pkg::T_DOT; fresh = 1'b1;
					end
				end
				stl_pkg::M_INT, stl_pkg::M_FRAC: begin
					if (stl_pkg::is_digit(c)) pos_d = pos_inc;
					else if (c == stl_pkg::CH_DOT && mode_q == stl_pkg::M_INT) begin
						mode_d = stl_pkg::M_FRAC; pos_d = pos_inc;
					end else begin
						nt = 2'd1; t0 = stl_pkg::T_NUMBER; fresh = 1'b1;
					end
				end
				stl_pkg::M_STRING: begin
					if (c == (quote_q ? stl_pkg::CH_SQ : stl_pkg::CH_DQ)) begin
						pos_d = pos_inc; nt = 2'd1; t0 = stl_pkg::T_STRING; e0 = pos_inc;
						mode_d = stl_pkg::M_IDLE;
					end else if (c == stl_pkg::CH_NL) begin
						nt = 2'd1; t0 = stl_pkg::T_ERROR; fresh = 1'b1;
					end else pos_d = pos_inc;
				end
				stl_pkg::M_IDENT: begin
					if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c) || c == stl_pkg::CH_UNDER) begin
						if (ilen_q < 4'd8) pfx_d = pfx_q | (64'(c) << {ilen_q[2:0], 3'b000});
						if (ilen_q < 4'd9) ilen_d = ilen_q + 1'b1;
						pos_d = pos_inc;
					end else begin
						nt = 2'd1; t0 = kw_type; pfx_d = '0; ilen_d = '0; fresh = 1'b1;
					end
				end
				default: fresh = 1'b1;
			endcase
			// Scan the byte with no token pending
			if (fresh) begin
				mode_d = stl_pkg::M_IDLE; start_d = pos_q; pos_d = pos_inc;
				if (c == 8'h20 || c == 8'h09 || c == 8'h0D) ;
				else if (c == stl_pkg::CH_NL) begin
					if (line_q < stl_pkg::LINE_W'(stl_pkg::LINE_MAX_COUNT)) line_d = line_q + 1'b1;
				end else if (c == stl_pkg::CH_HASH) mode_d = stl_pkg::M_COMMENT;
				else if (stl_pkg::is_digit(c)) mode_d = stl_pkg::M_INT;
				else if (stl_pkg::is_alpha(c) || c == stl_pkg::CH_UNDER) begin
					mode_d = stl_pkg::M_IDENT; pfx_d = 64'(c); ilen_d = 4'd1;
				end else if (c == stl_pkg::CH_DQ || c == stl_pkg::CH_SQ) begin
					mode_d = stl_pkg::M_STRING; quote_d = (c == stl_pkg::CH_SQ);
				end else if (stl_pkg::op_base(c) != '0) begin
					mode_d = stl_pkg::M_OP; pend_d = c;
				end else if (c == stl_pkg::CH_DOT) mode_d = stl_pkg::M_DOT;
				else begin
					case (c)
						8'h28: t1 = stl_pkg::T_LPAREN;
						8'h29: t1 = stl_pkg::T_RPAREN;
						8'h7B: t1 = stl_pkg::T_LBRACE;
						8'h7D: t1 = stl_pkg::T_RBRACE;
						8'h2C: t1 = stl_pkg::T_COMMA;
						8'h3B: t1 = stl_pkg::T_SEMI;
						default: t1 = stl_pkg::T_ERROR;
					endcase
					s1 = pos_q; e1 = pos_inc;
					if (nt == 2'd0) begin
						t0 = t1; s0 = s1; e0 = e1;
					end
					nt = nt + 1'b1;
				end
			end
		end
	end

	function automatic stl_pkg::tok_t mk(input logic [stl_pkg::TYPE_W-1:0] t,
		input logic [POS_W-1:0] s, input logic [POS_W-1:0] e,
		input logic [stl_pkg::LINE_W-1:0] ln, input logic lst);
		stl_pkg::tok_t r;
		logic [POS_W:0] len;
		len = (e >= s) ? {1'b0, e - s} : '0;
		r.token_type = t;
		r.start_offset = (POS_W'(s) > POS_W'(20'hFFFFF)) ? 20'hFFFFF : 20'(s);
		r.token_length = ((POS_W+1)'(len) > (POS_W+1)'(21'h1FFFFF)) ? 21'h1FFFFF : 21'(len);
		r.line_number = ln;
		r.last = lst;
		return r;
	endfunction

	// Line at emission: first token sees old line, fresh token sees it too
	stl_pkg::tok_t tok0, tok1;
	assign tok0 = mk(t0, s0, e0, line_q, nt == 2'd1);
	assign tok1 = mk(t1, s1, e1, line_q, 1'b1);

	logic pop;
	assign pop = out_ch.valid && out_ch.ready;
	assign out_ch.valid = cnt_q != 2'd0;
	assign out_ch.data  = qd_q[head_q];

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stl_pkg::M_IDLE; pend_q <= '0; quote_q <= 1'b0; start_q <= '0;
			pos_q <= '0; line_q <= stl_pkg::LINE_W'(1); pfx_q <= '0; ilen_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d; pend_q <= pend_d; quote_q <= quote_d; start_q <= start_d;
			pos_q <= pos_d; line_q <= line_d; pfx_q <= pfx_d; ilen_q <= ilen_d;
		end
	end

	// Result queue: pop from head, push one or two beats
	logic [1:0] cnt_after;
	logic       head_after;
	assign head_after = pop ? ~head_q : head_q;
	assign cnt_after  = cnt_q - {1'b0, pop};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; head_q <= 1'b0;
		end else begin
			head_q <= head_after;
			cnt_q <= cnt_after + ((fire) ? nt : 2'd0);
		end
	end
	always_ff @(posedge clk) begin
		if (fire && nt != 2'd0) begin
			qd_q[head_after ^ cnt_after[0]] <= tok0;
			if (nt == 2'd2) qd_q[~(head_after ^ cnt_after[0])] <= tok1;
		end
	end

	// No queue overflow, an accepted end resets the line count, scan mode one-hot
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("result queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) fire && endi |=> line_q == 21'd1)
		else $error("end of input did not reset line");
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(mode_q))
		else $error("scan mode not one-hot");
endmodule
